// File: src/ccm_pkg.sv
// Shared types, codes and helpers for the CIGAR coverage marker.
// Depends on nothing; imported by the top level.
package ccm_pkg;

    localparam int CURSOR_W            = 16;
    localparam int RUN_W               = CURSOR_W + 1;
    localparam int GENE_MAX_BASES_DEF  = 4096;
    localparam int WORD_BITS_DEF       = 64;
    localparam int WORD_BITS_MAX       = 64;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_CIGAR = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [3:0] OP_M  = 4'd0;
    localparam logic [3:0] OP_I  = 4'd1;
    localparam logic [3:0] OP_D  = 4'd2;
    localparam logic [3:0] OP_N  = 4'd3;
    localparam logic [3:0] OP_S  = 4'd4;
    localparam logic [3:0] OP_H  = 4'd5;
    localparam logic [3:0] OP_P  = 4'd6;
    localparam logic [3:0] OP_EQ = 4'd7;
    localparam logic [3:0] OP_X  = 4'd8;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [12:0] start_pos;
        logic [12:0] gene_len;
        logic [3:0]  op_code;
        logic [15:0] op_length;
    } ccm_in_t;

    typedef struct packed {
        logic [15:0] gene_pos;
        logic [15:0] read_pos;
        logic [12:0] covered_bases;
        logic [15:0] hit_total;
    } ccm_out_t;

    function automatic logic [6:0] popcnt64(input logic [WORD_BITS_MAX-1:0] v);
        logic [1:0] s1 [32];
        logic [2:0] s2 [16];
        logic [3:0] s3 [8];
        logic [4:0] s4 [4];
        logic [5:0] s5 [2];
        for (int i = 0; i < 32; i++)
        begin
            s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        end
        for (int i = 0; i < 16; i++)
        begin
            s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
        end
        for (int i = 0; i < 8; i++)
        begin
            s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
        end
        for (int i = 0; i < 4; i++)
        begin
            s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
        end
        for (int i = 0; i < 2; i++)
        begin
            s5[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
        end
        return {1'b0, s5[0]} + {1'b0, s5[1]};
    endfunction

endpackage

// File: src/cigar_coverage_marker_unit.sv
// Top level of the CIGAR coverage marker: sequencer, cursors, counters.
// Depends on ccm_pkg and ccm_ram (coverage bitmap, one word per entry).
//
//   channel | direction | handshake          | word
//   req     | in        | req_valid/req_stall | ccm_pkg::ccm_in_t
//   rsp     | out       | rsp_valid/rsp_stall | ccm_pkg::ccm_out_t
//
// Start, non-marking CIGAR and unknown items: ST_EXEC, then ST_RESULT loads the
// output register. M, = and X with a non-empty run add ST_MARK between them:
// a bitmap walk from word 0 through the word holding the run end, one RAM word per cycle.
// Clear: ST_CLEAR zeroes one bitmap word per cycle, then ST_RESULT.
// After reset ST_INIT zeroes the bitmap before the first word is accepted.
// One item at a time; a finished result waits in the output register.
module cigar_coverage_marker_unit #(
    parameter int GENE_MAX_BASES = ccm_pkg::GENE_MAX_BASES_DEF,
    parameter int WORD_BITS      = ccm_pkg::WORD_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  ccm_pkg::ccm_in_t  req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output ccm_pkg::ccm_out_t rsp
);

    import ccm_pkg::*;

    localparam int NUM_WORDS = (GENE_MAX_BASES + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
    localparam int CNT_W     = $clog2(GENE_MAX_BASES + 1);
    localparam int BASE_W    = $clog2(NUM_WORDS * WORD_BITS + 1);
    localparam int CW        = ((BASE_W > RUN_W) ? BASE_W : RUN_W) + 1;
    localparam int OFF_W     = $clog2(WORD_BITS + 1);
    localparam logic [ADDR_W-1:0]    LAST_ADDR = ADDR_W'(NUM_WORDS - 1);
    localparam logic [WORD_BITS-1:0] FULL      = {WORD_BITS{1'b1}};

    typedef enum logic [5:0] {
        ST_INIT   = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_EXEC   = 6'b000100,
        ST_MARK   = 6'b001000,
        ST_CLEAR  = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    logic [ADDR_W-1:0]     scan_reg, scan_next;
    logic [BASE_W-1:0]     base_reg, base_next;
    logic [RUN_W-1:0]      stop_reg, stop_next;
    ccm_in_t               item_reg, item_next;
    logic [CURSOR_W-1:0]   gene_reg, gene_next;
    logic [CURSOR_W-1:0]   read_reg, read_next;
    logic [CNT_W-1:0]      limit_reg, limit_next;
    logic [CNT_W-1:0]      covered_reg, covered_next;
    logic [15:0]           hit_reg, hit_next;
    logic                  pend_reg, pend_next;
    logic [ADDR_W-1:0]     wr_addr_reg, wr_addr_next;
    logic [WORD_BITS-1:0]  mask_reg, mask_next;
    logic [WORD_BITS-1:0]  new_bits_reg, new_bits_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    ccm_out_t              rsp_reg, rsp_next;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [WORD_BITS-1:0]  ram_rdata;

    logic                  accept;
    logic                  mark_active;
    logic [CW-1:0]         first_c, base_c, stop_c, lo_diff, hi_diff;
    logic [OFF_W-1:0]      lo_off, hi_off;
    logic [WORD_BITS-1:0]  mask_calc;
    logic [RUN_W-1:0]      run_sum, lim_ext, stop_calc, run_len, read_sum;
    logic [RUN_W-1:0]      len_sum_gene, len_sum_read;

    ccm_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        first_c     = CW'(gene_reg);
        base_c      = CW'(base_reg);
        stop_c      = CW'(stop_reg);
        mark_active = base_c < stop_c;
        lo_diff     = first_c - base_c;
        hi_diff     = stop_c - base_c;
        if (first_c <= base_c)
        begin
            lo_off = '0;
        end
        else if (lo_diff >= CW'(WORD_BITS))
        begin
            lo_off = OFF_W'(WORD_BITS);
        end
        else
        begin
            lo_off = OFF_W'(lo_diff);
        end
        if (hi_diff >= CW'(WORD_BITS))
        begin
            hi_off = OFF_W'(WORD_BITS);
        end
        else
        begin
            hi_off = OFF_W'(hi_diff);
        end
        mask_calc = (FULL << lo_off) & ~(FULL << hi_off);

        run_sum      = RUN_W'(gene_reg) + RUN_W'(item_reg.op_length);
        lim_ext      = RUN_W'(limit_reg);
        stop_calc    = (run_sum > lim_ext) ? lim_ext : run_sum;
        len_sum_gene = run_sum;
        len_sum_read = RUN_W'(read_reg) + RUN_W'(item_reg.op_length);
        run_len      = stop_reg - RUN_W'(gene_reg);
        read_sum     = RUN_W'(read_reg) + run_len;
    end

    always_comb
    begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        base_next      = base_reg;
        stop_next      = stop_reg;
        item_next      = item_reg;
        gene_next      = gene_reg;
        read_next      = read_reg;
        limit_next     = limit_reg;
        covered_next   = covered_reg;
        hit_next       = hit_reg;
        pend_next      = 1'b0;
        wr_addr_next   = wr_addr_reg;
        mask_next      = mask_reg;
        new_bits_next  = '0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = scan_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = scan_reg;

        case (state_reg)
            ST_INIT:
            begin
                ram_we = 1'b1;
                if (scan_reg == LAST_ADDR)
                begin
                    scan_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + ADDR_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next  = req;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_RESULT;
                case (item_reg.req_type)
                    REQ_START:
                    begin
                        gene_next = (item_reg.start_pos == '0) ? '0 :
                                    CURSOR_W'(item_reg.start_pos - 13'd1);
                        read_next = '0;
                        if (CW'(item_reg.gene_len) > CW'(GENE_MAX_BASES))
                        begin
                            limit_next = CNT_W'(GENE_MAX_BASES);
                        end
                        else
                        begin
                            limit_next = CNT_W'(item_reg.gene_len);
                        end
                        if (hit_reg != 16'hFFFF)
                        begin
                            hit_next = hit_reg + 16'd1;
                        end
                    end
                    REQ_CIGAR:
                    begin
                        case (item_reg.op_code)
                            OP_M, OP_EQ, OP_X:
                            begin
                                stop_next = stop_calc;
                                scan_next = '0;
                                base_next = '0;
                                if (stop_calc > RUN_W'(gene_reg))
                                begin
                                    state_next = ST_MARK;
                                end
                            end
                            OP_D, OP_N:
                            begin
                                gene_next = len_sum_gene[CURSOR_W] ? {CURSOR_W{1'b1}} :
                                            len_sum_gene[CURSOR_W-1:0];
                            end
                            OP_I, OP_S:
                            begin
                                read_next = len_sum_read[CURSOR_W] ? {CURSOR_W{1'b1}} :
                                            len_sum_read[CURSOR_W-1:0];
                            end
                            default:
                            begin
                                state_next = ST_RESULT;
                            end
                        endcase
                    end
                    REQ_CLEAR:
                    begin
                        covered_next = '0;
                        hit_next     = '0;
                        scan_next    = '0;
                        state_next   = ST_CLEAR;
                    end
                    default:
                    begin
                        state_next = ST_RESULT;
                    end
                endcase
            end
            ST_MARK:
            begin
                covered_next = covered_reg + CNT_W'(popcnt64(WORD_BITS_MAX'(new_bits_reg)));
                if (pend_reg)
                begin
                    ram_we        = 1'b1;
                    ram_waddr     = wr_addr_reg;
                    ram_wdata     = ram_rdata | mask_reg;
                    new_bits_next = mask_reg & ~ram_rdata;
                end
                if (mark_active)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = scan_reg;
                    mask_next    = mask_calc;
                    pend_next    = 1'b1;
                    wr_addr_next = scan_reg;
                    scan_next    = scan_reg + ADDR_W'(1);
                    base_next    = base_reg + BASE_W'(WORD_BITS);
                end
                else if (!pend_reg)
                begin
                    gene_next  = stop_reg[CURSOR_W] ? {CURSOR_W{1'b1}} :
                                 stop_reg[CURSOR_W-1:0];
                    read_next  = read_sum[CURSOR_W] ? {CURSOR_W{1'b1}} :
                                 read_sum[CURSOR_W-1:0];
                    state_next = ST_RESULT;
                end
            end
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                if (scan_reg == LAST_ADDR)
                begin
                    scan_next  = '0;
                    state_next = ST_RESULT;
                end
                else
                begin
                    scan_next = scan_reg + ADDR_W'(1);
                end
            end
            ST_RESULT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.gene_pos      = gene_reg;
                    rsp_next.read_pos      = read_reg;
                    rsp_next.covered_bases = 13'(covered_reg);
                    rsp_next.hit_total     = hit_reg;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            scan_reg      <= '0;
            gene_reg      <= '0;
            read_reg      <= '0;
            limit_reg     <= '0;
            covered_reg   <= '0;
            hit_reg       <= '0;
            pend_reg      <= 1'b0;
            new_bits_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            gene_reg      <= gene_next;
            read_reg      <= read_next;
            limit_reg     <= limit_next;
            covered_reg   <= covered_next;
            hit_reg       <= hit_next;
            pend_reg      <= pend_next;
            new_bits_reg  <= new_bits_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg    <= base_next;
        stop_reg    <= stop_next;
        item_reg    <= item_next;
        wr_addr_reg <= wr_addr_next;
        mask_reg    <= mask_next;
        rsp_reg     <= rsp_next;
    end

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("bitmap read and write hit the same word");

    a_covered_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(covered_reg) <= CW'(GENE_MAX_BASES))
        else $error("covered count beyond bitmap size");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC))
        else $error("accepted word not executed");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RESULT) && (!rsp_valid_reg || !rsp_stall)) |=> rsp_valid_reg)
        else $error("result not presented");

endmodule

// File: src/ccm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module ccm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: verif/tb_cigar_coverage_marker_unit.sv
// Self-checking testbench for cigar_coverage_marker_unit: a scoreboard class predicts
// cursors, covered-base count and hit count per request word and checks each response.
// Depends on ccm_pkg and the RTL of the unit only.
module tb_cigar_coverage_marker_unit;
    import ccm_pkg::*;

    localparam int          CURSOR_MAX    = (1 << CURSOR_W) - 1;
    localparam int          HIT_MAX       = 65535;
    localparam logic [1:0]  REQ_UNUSED    = 2'd3;
    localparam logic [3:0]  OP_FIRST_BAD  = 4'd9;
    localparam logic [3:0]  OP_LAST_CODE  = 4'd15;
    localparam int          IDLE_LIMIT    = 1000;
    localparam int          DRAIN_CYCLES  = 100;
    localparam int          RANDOM_WORDS  = 950;

    class coverage_scoreboard;
        bit          base_marked [GENE_MAX_BASES_DEF];
        int unsigned gene_cur;
        int unsigned read_cur;
        int unsigned gene_lim;
        int unsigned covered;
        int unsigned hits;
        ccm_out_t    expected_q [$];
        int          errors;

        function int unsigned sat_cursor(int unsigned a, int unsigned b);
            return (a + b > CURSOR_MAX) ? CURSOR_MAX : a + b;
        endfunction

        function void note_request(ccm_in_t w);
            int unsigned stop;
            ccm_out_t    want;
            case (w.req_type)
                REQ_START:
                begin
                    gene_cur = (w.start_pos == 0) ? 0 : w.start_pos - 1;
                    read_cur = 0;
                    gene_lim = (w.gene_len > GENE_MAX_BASES_DEF) ? GENE_MAX_BASES_DEF
                                                                  : w.gene_len;
                    if (hits < HIT_MAX)
                        hits++;
                end
                REQ_CIGAR:
                begin
                    case (w.op_code)
                        OP_M, OP_EQ, OP_X:
                        begin
                            stop = gene_cur + w.op_length;
                            if (stop > gene_lim)
                                stop = gene_lim;
                            if (gene_cur < stop)
                            begin
                                for (int unsigned i = gene_cur; i < stop; i++)
                                begin
                                    if (!base_marked[i])
                                    begin
                                        base_marked[i] = 1'b1;
                                        covered++;
                                    end
                                end
                                read_cur = sat_cursor(read_cur, stop - gene_cur);
                                gene_cur = sat_cursor(gene_cur, stop - gene_cur);
                            end
                        end
                        OP_D, OP_N: gene_cur = sat_cursor(gene_cur, w.op_length);
                        OP_I, OP_S: read_cur = sat_cursor(read_cur, w.op_length);
                        default: ;
                    endcase
                end
                REQ_CLEAR:
                begin
                    foreach (base_marked[i])
                        base_marked[i] = 1'b0;
                    covered = 0;
                    hits    = 0;
                end
                default: ;
            endcase
            want.gene_pos      = gene_cur[15:0];
            want.read_pos      = read_cur[15:0];
            want.covered_bases = covered[12:0];
            want.hit_total     = hits[15:0];
            expected_q.push_back(want);
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(ccm_out_t got);
            ccm_out_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: response expected none actual gene_pos %0d read_pos %0d %s %0d %s %0d",
                         $time, got.gene_pos, got.read_pos, "covered_bases", got.covered_bases,
                         "hit_total", got.hit_total);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("gene_pos", 32'(want.gene_pos), 32'(got.gene_pos));
            compare_field("read_pos", 32'(want.read_pos), 32'(got.read_pos));
            compare_field("covered_bases", 32'(want.covered_bases), 32'(got.covered_bases));
            compare_field("hit_total", 32'(want.hit_total), 32'(got.hit_total));
        endfunction
    endclass

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    ccm_in_t  req       = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    ccm_out_t rsp;

    coverage_scoreboard sb = new;
    bit pace_gaps   = 1'b1;
    int words_sent  = 0;
    int quiet_cycles = 0;

    cigar_coverage_marker_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet_cycles++;
            if (req_valid && !req_stall)
            begin
                sb.note_request(req);
                quiet_cycles = 0;
            end
            if (rsp_valid && !rsp_stall)
            begin
                sb.check_result(rsp);
                quiet_cycles = 0;
            end
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("cigar_coverage_marker_unit verification failed");
                $finish;
            end
        end
    end

    function automatic ccm_in_t build_req(logic [1:0] kind, logic [12:0] spos,
                                          logic [12:0] glen, logic [3:0] op,
                                          logic [15:0] olen);
        ccm_in_t w;
        w.req_type  = kind;
        w.start_pos = spos;
        w.gene_len  = glen;
        w.op_code   = op;
        w.op_length = olen;
        return w;
    endfunction

    task automatic send_word(input ccm_in_t w);
        int gap;
        gap = pace_gaps ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        words_sent++;
    endtask

    initial
    begin
        int n;
        @(posedge clk);
        forever
        begin
            n = pace_gaps ? $urandom_range(0, 4) : 0;
            if (n > 0)
            begin
                rsp_stall <= 1'b1;
                @(posedge clk);
                while (!rsp_valid)
                    @(posedge clk);
                repeat (n - 1) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
        end
    end

    task automatic run_directed();
        send_word(build_req(REQ_CIGAR, 0, 0, OP_M, 16'd20));
        send_word(build_req(REQ_START, 13'd1, 13'd100, OP_M, 0));
        send_word(build_req(REQ_CIGAR, 0, 0, OP_M, 16'd10));
        send_word(build_req(REQ_CIGAR, 0, 0, OP_EQ, 16'd5));
        send_word(build_req(REQ_CIGAR, 0, 0, OP_X, 16'd5));
        send_word(build_req(REQ_CIGAR, 0, 0, OP_I, 16'd3));
        send_word(build_req(REQ_CIGAR, 0, 0, OP_S, 16'd2));
        send_word(build_req(REQ_CIGAR, 0, 0, OP_D, 16'd4));
        send_word(build_req(REQ_CIGAR, 0, 0, OP_N, 16'd1));
        send_word(build_req(REQ_CIGAR, 0, 0, OP_H, 16'd7));
        send_word(build_req(REQ_CIGAR, 0, 0, OP_P, 16'd9));
        send_word(build_req(REQ_CIGAR, 0, 0, OP_FIRST_BAD, 16'd4));
        send_word(build_req(REQ_CIGAR, 0, 0, OP_LAST_CODE, 16'd4));
        send_word(build_req(REQ_UNUSED, 13'h1FFF, 13'h1FFF, OP_M, 16'hFFFF));
        send_word(build_req(REQ_CIGAR, 0, 0, OP_M, 16'd0));
        send_word(build_req(REQ_CIGAR, 0, 0, OP_M, 16'd200));
        send_word(build_req(REQ_START, 13'd0, 13'h1FFF, OP_M, 0));
        send_word(build_req(REQ_CIGAR, 0, 0, OP_M, 16'hFFFF));
        send_word(build_req(REQ_CIGAR, 0, 0, OP_EQ, 16'd1));
        send_word(build_req(REQ_START, 13'h1FFF, 13'd0, OP_M, 0));
        send_word(build_req(REQ_CIGAR, 0, 0, OP_D, 16'hFFFF));
        send_word(build_req(REQ_CIGAR, 0, 0, OP_N, 16'hFFFF));
        send_word(build_req(REQ_CIGAR, 0, 0, OP_I, 16'hFFFF));
        send_word(build_req(REQ_CIGAR, 0, 0, OP_S, 16'hFFFF));
        send_word(build_req(REQ_START, 13'd4096, 13'd4096, OP_M, 0));
        send_word(build_req(REQ_CIGAR, 0, 0, OP_X, 16'd1));
        send_word(build_req(REQ_CLEAR, 0, 0, OP_M, 0));
    endtask

    task automatic run_random(input int count);
        int          last_word;
        int          roll;
        int          ops;
        logic [12:0] glen;
        logic [12:0] spos;
        logic [3:0]  op;
        logic [15:0] olen;
        logic [63:0] raw;
        last_word = words_sent + count;
        while (words_sent < last_word)
        begin
            if ($urandom_range(0, 9) == 0)
                pace_gaps = $urandom_range(0, 3) != 0;
            roll = $urandom_range(0, 99);
            if (roll < 4)
            begin
                send_word(build_req(REQ_CLEAR, 13'($urandom()), 13'($urandom()),
                                    4'($urandom()), 16'($urandom())));
            end
            else if (roll < 10)
            begin
                raw = {$urandom(), $urandom()};
                send_word(raw[$bits(ccm_in_t)-1:0]);
            end
            else
            begin
                roll = $urandom_range(0, 9);
                glen = 13'((roll < 8) ? $urandom_range(1, 4096)
                         : (roll == 8) ? $urandom_range(1, 64) : $urandom_range(0, 8191));
                spos = 13'(($urandom_range(0, 9) < 7 && glen != 0) ? $urandom_range(1, glen)
                                                                    : $urandom_range(0, 8191));
                send_word(build_req(REQ_START, spos, glen, 4'($urandom()), 16'($urandom())));
                ops = $urandom_range(1, 8);
                repeat (ops)
                begin
                    op = 4'(($urandom_range(0, 9) != 0) ? $urandom_range(OP_M, OP_X)
                                                        : $urandom_range(OP_FIRST_BAD,
                                                                         OP_LAST_CODE));
                    roll = $urandom_range(0, 9);
                    olen = 16'((roll < 7) ? $urandom_range(0, 150)
                             : (roll < 9) ? $urandom_range(0, 4096) : $urandom_range(0, 65535));
                    send_word(build_req(REQ_CIGAR, 13'($urandom()), 13'($urandom()), op, olen));
                end
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random(RANDOM_WORDS);
        req_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("cigar_coverage_marker_unit verification clean");
        else
            $display("cigar_coverage_marker_unit verification failed");
        $finish;
    end
endmodule
